// File: hdl/olasr_pkg.sv
// Package for the ordered list core: action and status codes and field widths.
// It has no dependencies. The core and its testbench import it.
`default_nettype none
package olasr_pkg;

   localparam int ActionWidth = 2;
   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 2;
   localparam int CountWidth  = 5;

   localparam logic [ActionWidth-1:0] ACT_APPEND = 2'd0;
   localparam logic [ActionWidth-1:0] ACT_SEARCH = 2'd1;
   localparam logic [ActionWidth-1:0] ACT_REMOVE = 2'd2;

   localparam logic [StatusWidth-1:0] STAT_DONE      = 2'd0;
   localparam logic [StatusWidth-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [StatusWidth-1:0] STAT_FULL      = 2'd2;
   localparam logic [StatusWidth-1:0] STAT_EMPTY     = 2'd3;

endpackage
`default_nettype wire

// File: hdl/olasr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// It has no dependencies.
`default_nettype none
module olasr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/ordered_list_append_search_remove_core.sv
// Ordered list core: append at the tail, search, and remove with gap closing.
// An append writes at the tail directly. A search or remove reads and compares each
// entry walked through the single RAM read port, and a remove then reads and writes
// each later entry to shift it down; one item is in work at a time.
// A synchronous reset empties the list; stored entries are not cleared.
// Depends on olasr_pkg and olasr_ram.
`default_nettype none
module ordered_list_append_search_remove_core #(
   parameter int DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [olasr_pkg::ActionWidth-1:0]   req_action,
   input  wire logic signed [olasr_pkg::ValueWidth-1:0] req_value,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [olasr_pkg::StatusWidth-1:0]   rsp_status,
   output      logic [olasr_pkg::CountWidth-1:0]    rsp_entry_count
);

   import olasr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DepthCount = CW'(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_SHIFT_READ,
      ST_SHIFT_WRITE,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           total_ff, total_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic                    remove_ff, remove_in;
   logic [ValueWidth-1:0]   value_ff, value_in;
   logic [StatusWidth-1:0]  status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [StatusWidth-1:0]  rsp_status_ff, rsp_status_in;
   logic [CountWidth-1:0]   rsp_count_ff, rsp_count_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [ValueWidth-1:0]   wr_data;
   logic [AW-1:0]           rd_addr;
   logic [ValueWidth-1:0]   rd_data;

   logic [CW-1:0]           idx_next;
   logic [CW:0]             idx_plus2;
   logic [CW+CountWidth-1:0] count_wide;

   assign idx_next   = CW'(idx_ff + 1'b1);
   assign idx_plus2  = {1'b0, idx_ff} + (CW+1)'(2);
   assign count_wide = {{CountWidth{1'b0}}, total_ff};

   olasr_ram #(
      .WIDTH (ValueWidth),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      remove_in     = remove_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = total_ff[AW-1:0];
      wr_data       = req_value;
      rd_addr       = idx_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               remove_in = (req_action == ACT_REMOVE);
               value_in  = req_value;
               idx_in    = '0;
               state_in  = ST_FINISH;
               case (req_action) inside
                  ACT_APPEND: begin
                     if (total_ff == DepthCount) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        total_in  = CW'(total_ff + 1'b1);
                        status_in = STAT_DONE;
                     end
                  end
                  ACT_SEARCH, ACT_REMOVE: begin
                     if (total_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     status_in = STAT_NOT_FOUND;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (rd_data == value_ff) begin
               if (remove_ff && (idx_next < total_ff)) begin
                  state_in = ST_SHIFT_READ;
               end else begin
                  if (remove_ff) begin
                     total_in = CW'(total_ff - 1'b1);
                  end
                  status_in = STAT_DONE;
                  state_in  = ST_FINISH;
               end
            end else if (idx_next == total_ff) begin
               status_in = STAT_NOT_FOUND;
               state_in  = ST_FINISH;
            end else begin
               idx_in   = idx_next;
               state_in = ST_READ;
            end
         end
         ST_SHIFT_READ: begin
            rd_addr  = idx_next[AW-1:0];
            state_in = ST_SHIFT_WRITE;
         end
         ST_SHIFT_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            idx_in  = idx_next;
            if (idx_plus2 < {1'b0, total_ff}) begin
               state_in = ST_SHIFT_READ;
            end else begin
               total_in  = CW'(total_ff - 1'b1);
               status_in = STAT_DONE;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_wide[CountWidth-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      remove_ff     <= remove_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
`default_nettype wire

// File: sim/ordered_list_append_search_remove_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ordered list core: directed and random appends, searches
// and removes, each result checked against a queue model of the list kept in a scoreboard.
// Depends on olasr_pkg and on ordered_list_append_search_remove_core with its RAM.

typedef struct packed {
   logic [olasr_pkg::StatusWidth-1:0] status;
   logic [olasr_pkg::CountWidth-1:0]  entry_count;
} list_outcome_t;

class list_scoreboard #(int Depth = 16);
   localparam int ReportLimit = 10;

   logic [olasr_pkg::ValueWidth-1:0] held_values[$];
   list_outcome_t pending_outcomes[$];
   int mismatches;
   int action_seen[4];
   int status_seen[4];

   function void note_request(logic [olasr_pkg::ActionWidth-1:0] action,
                              logic [olasr_pkg::ValueWidth-1:0] value);
      list_outcome_t outcome;
      int pos;
      pos = -1;
      outcome.status = olasr_pkg::STAT_DONE;
      case (action)
         olasr_pkg::ACT_APPEND: begin
            if (held_values.size() >= Depth) outcome.status = olasr_pkg::STAT_FULL;
            else held_values.push_back(value);
         end
         olasr_pkg::ACT_SEARCH, olasr_pkg::ACT_REMOVE: begin
            if (held_values.size() == 0) begin
               outcome.status = olasr_pkg::STAT_EMPTY;
            end else begin
               foreach (held_values[i])
                  if (pos < 0 && held_values[i] === value) pos = i;
               if (pos < 0) outcome.status = olasr_pkg::STAT_NOT_FOUND;
               else if (action == olasr_pkg::ACT_REMOVE) held_values.delete(pos);
            end
         end
         default: outcome.status = olasr_pkg::STAT_NOT_FOUND;
      endcase
      outcome.entry_count = olasr_pkg::CountWidth'(held_values.size());
      action_seen[action]++;
      pending_outcomes.push_back(outcome);
   endfunction

   function void check_response(logic [olasr_pkg::StatusWidth-1:0] status,
                                logic [olasr_pkg::CountWidth-1:0] entry_count);
      list_outcome_t want;
      if (pending_outcomes.size() == 0) begin
         mismatches++;
         if (mismatches <= ReportLimit)
            $display("Unexpected result transfer: status %0d, count %0d", status, entry_count);
         return;
      end
      want = pending_outcomes.pop_front();
      status_seen[want.status]++;
      if (status !== want.status || entry_count !== want.entry_count) begin
         mismatches++;
         if (mismatches <= ReportLimit)
            $display("Mismatch: expected status %0d count %0d, got status %0d count %0d",
                     want.status, want.entry_count, status, entry_count);
      end
   endfunction
endclass

module ordered_list_append_search_remove_core_test;
   import olasr_pkg::*;

   typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_MIXED} lean_t;

   localparam int ListDepth    = 16;
   localparam int ItemTotal    = 1350;
   localparam int CalmItems    = 150;
   localparam int PauseItem    = 700;
   localparam int CycleLimit   = 1000000;
   localparam int SettleCycles = 4 * ListDepth + 8;
   localparam logic [ActionWidth-1:0] ACT_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ActionWidth-1:0] req_action = ACT_APPEND;
   logic signed [ValueWidth-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [StatusWidth-1:0] rsp_status;
   logic [CountWidth-1:0] rsp_entry_count;

   list_scoreboard #(ListDepth) sb = new;
   bit calm_tail = 1'b0;
   int cycle_count = 0;
   int items_sent = 0;
   logic [ValueWidth-1:0] value_pool[8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_002A};

   always #5 clock = ~clock;

   ordered_list_append_search_remove_core #(.DEPTH(ListDepth)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_response(rsp_status, rsp_entry_count);
   end

   initial begin
      int span;
      forever begin
         span = $urandom_range(1, 13);
         if (!calm_tail && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            span = $urandom_range(1, 40);
         end
         repeat (span) @(posedge clock);
      end
   end

   task automatic send_item(input logic [ActionWidth-1:0] action,
                            input logic [ValueWidth-1:0] value);
      int gap;
      req_valid  <= 1'b1;
      req_action <= action;
      req_value  <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(action, value);
      items_sent++;
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [ActionWidth-1:0] pick_action(lean_t lean);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return ACT_UNUSED;
      case (lean)
         LEAN_FILL:  return roll < 70 ? ACT_APPEND : (roll < 85 ? ACT_SEARCH : ACT_REMOVE);
         LEAN_DRAIN: return roll < 25 ? ACT_APPEND : (roll < 45 ? ACT_SEARCH : ACT_REMOVE);
         default:    return roll < 45 ? ACT_APPEND : (roll < 70 ? ACT_SEARCH : ACT_REMOVE);
      endcase
   endfunction

   // Lookups mostly target a value that is held, so that removes reach every position.
   function automatic logic [ValueWidth-1:0] pick_value(bit for_lookup);
      int roll;
      roll = $urandom_range(0, 99);
      if (for_lookup && sb.held_values.size() != 0 && roll < 65)
         return sb.held_values[$urandom_range(0, sb.held_values.size() - 1)];
      if (roll % 2 == 0) return value_pool[$urandom_range(0, 7)];
      return $urandom();
   endfunction

   initial begin
      lean_t lean;
      logic [ActionWidth-1:0] action;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(ACT_SEARCH, 32'h0000_0005);
      send_item(ACT_REMOVE, 32'h0000_0005);
      send_item(ACT_UNUSED, 32'hFFFF_FFFF);
      send_item(ACT_APPEND, 32'h8000_0000);
      send_item(ACT_REMOVE, 32'h8000_0000);
      send_item(ACT_APPEND, 32'h7FFF_FFFF);
      send_item(ACT_APPEND, 32'h0000_0000);
      send_item(ACT_APPEND, 32'hFFFF_FFFF);
      send_item(ACT_SEARCH, 32'h0000_0000);
      send_item(ACT_REMOVE, 32'h1234_5678);
      send_item(ACT_REMOVE, 32'h0000_0000);
      send_item(ACT_REMOVE, 32'hFFFF_FFFF);
      for (int i = 0; i < ListDepth - 1; i++)
         send_item(ACT_APPEND, i[0] ? 32'hAAAA_AAAA : 32'h5555_5555);
      send_item(ACT_APPEND, 32'h0000_0001);

      lean = LEAN_MIXED;
      while (items_sent < ItemTotal) begin
         if (items_sent % 40 == 0) lean = lean_t'($urandom_range(0, 2));
         if (items_sent >= ItemTotal - CalmItems) calm_tail = 1'b1;
         if (items_sent == PauseItem) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.pending_outcomes.size() != 0);
         end
         action = pick_action(lean);
         send_item(action, pick_value(action == ACT_SEARCH || action == ACT_REMOVE));
      end

      req_valid <= 1'b0;
      while (sb.pending_outcomes.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("Covered %0d transfers: %0d appends, %0d searches, %0d removes, %0d unused codes.",
               items_sent, sb.action_seen[ACT_APPEND], sb.action_seen[ACT_SEARCH],
               sb.action_seen[ACT_REMOVE], sb.action_seen[ACT_UNUSED]);
      $display("Results: %0d done, %0d not found, %0d full, %0d empty; %0d mismatches.",
               sb.status_seen[STAT_DONE], sb.status_seen[STAT_NOT_FOUND],
               sb.status_seen[STAT_FULL], sb.status_seen[STAT_EMPTY], sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
